/* hdl/rne_pkg.sv */
// ----------------------------------------------------------------------------
// rne_pkg: shared types and constants of the roman numeral encoder
// holds the greedy value table, its letters and the queue request type
// ----------------------------------------------------------------------------
package rne_pkg;

    localparam int unsigned ValueWidth = 12;
    localparam int unsigned CharWidth  = 7;
    localparam int unsigned PosWidth   = 4;
    localparam int unsigned TableLen   = 13;

    // ascii codes of the numeral letters
    localparam logic [CharWidth-1:0] CharM = 7'h4D;
    localparam logic [CharWidth-1:0] CharD = 7'h44;
    localparam logic [CharWidth-1:0] CharC = 7'h43;
    localparam logic [CharWidth-1:0] CharL = 7'h4C;
    localparam logic [CharWidth-1:0] CharX = 7'h58;
    localparam logic [CharWidth-1:0] CharV = 7'h56;
    localparam logic [CharWidth-1:0] CharI = 7'h49;
    localparam logic [CharWidth-1:0] CharNone = 7'h00;

    // request from the front part into the queue
    typedef struct packed {
        logic                  valid;
        logic [ValueWidth-1:0] value;
    } t_q_req;

    // value of each table entry, largest first
    function automatic logic [ValueWidth-1:0] step_value(input logic [PosWidth-1:0] p);
        logic [ValueWidth-1:0] v;
        case (p)
            4'd0:    v = 12'd1000;
            4'd1:    v = 12'd900;
            4'd2:    v = 12'd500;
            4'd3:    v = 12'd400;
            4'd4:    v = 12'd100;
            4'd5:    v = 12'd90;
            4'd6:    v = 12'd50;
            4'd7:    v = 12'd40;
            4'd8:    v = 12'd10;
            4'd9:    v = 12'd9;
            4'd10:   v = 12'd5;
            4'd11:   v = 12'd4;
            default: v = 12'd1;
        endcase
        return v;
    endfunction

    // leading letter of each table entry
    function automatic logic [CharWidth-1:0] first_char(input logic [PosWidth-1:0] p);
        logic [CharWidth-1:0] c;
        case (p)
            4'd0:    c = CharM;
            4'd1:    c = CharC;
            4'd2:    c = CharD;
            4'd3:    c = CharC;
            4'd4:    c = CharC;
            4'd5:    c = CharX;
            4'd6:    c = CharL;
            4'd7:    c = CharX;
            4'd8:    c = CharX;
            4'd9:    c = CharI;
            4'd10:   c = CharV;
            default: c = CharI;
        endcase
        return c;
    endfunction

    // trailing letter of a subtractive pair, none for single letters
    function automatic logic [CharWidth-1:0] second_char(input logic [PosWidth-1:0] p);
        logic [CharWidth-1:0] c;
        case (p)
            4'd1:    c = CharM;
            4'd3:    c = CharD;
            4'd5:    c = CharC;
            4'd7:    c = CharL;
            4'd9:    c = CharX;
            4'd11:   c = CharV;
            default: c = CharNone;
        endcase
        return c;
    endfunction

endpackage

/* hdl/rne_front.sv */
// ----------------------------------------------------------------------------
// rne_front: input stage of the roman numeral encoder
// registers incoming values, drops zeros and pushes the rest to the queue
// ----------------------------------------------------------------------------
module rne_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [rne_pkg::ValueWidth-1:0] i_value,
    output rne_pkg::t_q_req                o_push,
    input  logic                           i_push_ready
);

    logic                           r_valid;
    logic [rne_pkg::ValueWidth-1:0] r_value;
    logic                           n_valid;

    // stage frees up when empty or when its request moves into the queue
    assign o_ready = !r_valid || i_push_ready;

    // zero values produce no characters and are dropped here
    always_comb begin
        n_valid = r_valid && !i_push_ready;
        if (i_valid && o_ready) begin
            n_valid = (i_value != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_value <= i_value;
        end
    end

    assign o_push.valid = r_valid;
    assign o_push.value = r_value;

endmodule

/* hdl/rne_queue.sv */
// ----------------------------------------------------------------------------
// rne_queue: two-entry queue between the front and back parts
// lets the input side keep accepting while a numeral is still being sent
// ----------------------------------------------------------------------------
module rne_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rne_pkg::t_q_req                i_push,
    output logic                           o_push_ready,
    output rne_pkg::t_q_req                o_head,
    input  logic                           i_pop
);

    logic [rne_pkg::ValueWidth-1:0] r_mem [2];
    logic                           r_wr_ptr;
    logic                           r_rd_ptr;
    logic [1:0]                     r_count;
    logic                           w_push;
    logic                           w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign w_push       = i_push.valid && o_push_ready;
    assign w_pop        = i_pop && (r_count != 2'd0);

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.value = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.value;
        end
    end

endmodule

/* hdl/rne_back.sv */
// ----------------------------------------------------------------------------
// rne_back: greedy numeral engine of the roman numeral encoder
// emits one character per cycle, while the output is not stalled, into an output register with last flag
// ----------------------------------------------------------------------------
module rne_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rne_pkg::t_q_req               i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rne_pkg::CharWidth-1:0] o_char,
    output logic                          o_last
);

    logic [rne_pkg::ValueWidth-1:0] r_rem;
    logic [rne_pkg::PosWidth-1:0]   r_pos;
    logic                           r_pending;
    logic                           r_busy;
    logic [rne_pkg::CharWidth-1:0]  r_second;
    logic                           r_ovalid;
    logic [rne_pkg::CharWidth-1:0]  r_char;
    logic                           r_last;

    logic [rne_pkg::PosWidth-1:0]   w_sel;
    logic                           w_slot_free;
    logic                           w_emit;
    logic [rne_pkg::ValueWidth-1:0] w_rem_sub;
    logic [rne_pkg::CharWidth-1:0]  w_sec_sel;
    logic                           w_is_pair;

    assign w_slot_free = !r_ovalid || i_ready;
    assign w_emit      = r_busy && w_slot_free;
    assign o_pop       = !r_busy && i_head.valid;

    // first table entry at or after the current position that fits
    always_comb begin
        w_sel = 4'(rne_pkg::TableLen - 1);
        for (int i = rne_pkg::TableLen - 1; i >= 0; i--) begin
            if ((4'(i) >= r_pos) && (r_rem >= rne_pkg::step_value(4'(i)))) begin
                w_sel = 4'(i);
            end
        end
    end

    assign w_rem_sub = r_rem - rne_pkg::step_value(w_sel);
    assign w_sec_sel = rne_pkg::second_char(w_sel);
    assign w_is_pair = (w_sec_sel != rne_pkg::CharNone);

    // engine control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem     <= '0;
            r_pos     <= '0;
            r_pending <= 1'b0;
            r_busy    <= 1'b0;
        end else if (o_pop) begin
            r_rem     <= i_head.value;
            r_pos     <= '0;
            r_pending <= 1'b0;
            r_busy    <= 1'b1;
        end else if (w_emit) begin
            if (r_pending) begin
                r_pending <= 1'b0;
                r_busy    <= (r_rem != '0);
            end else begin
                r_rem     <= w_rem_sub;
                r_pos     <= w_sel;
                r_pending <= w_is_pair;
                r_busy    <= w_is_pair || (w_rem_sub != '0);
            end
        end
    end

    // second letter of a pair waits here until the engine emits again
    always_ff @(posedge i_clk) begin
        if (w_emit && !r_pending) begin
            r_second <= w_sec_sel;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (r_pending) begin
                r_char <= r_second;
                r_last <= (r_rem == '0);
            end else begin
                r_char <= rne_pkg::first_char(w_sel);
                r_last <= !w_is_pair && (w_rem_sub == '0);
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_char  = r_char;
    assign o_last  = r_last;

    // a pending pair letter only exists inside a busy numeral
    a_pending_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> r_busy)
        else $error("pair letter pending while engine idle");

    // a busy engine with no pair letter due still has value left
    a_busy_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !r_pending) |-> (r_rem != '0))
        else $error("engine busy with nothing left to encode");

    // an emitted first letter always comes from an entry that fits
    a_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && !r_pending) |-> (r_rem >= rne_pkg::step_value(w_sel)))
        else $error("selected table entry exceeds remaining value");

    // no new value is taken while a numeral is in progress
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_pop)
        else $error("queue popped while engine busy");

endmodule

/* hdl/roman_numeral_encoder.sv */
// ----------------------------------------------------------------------------
// roman_numeral_encoder: 12-bit unsigned value to roman numeral ascii stream
// front stage, two-entry queue and greedy engine with an output register
// ----------------------------------------------------------------------------
// Each accepted value leaves as its roman numeral, one ascii character per
// output request, tlast on the final character; a value of zero produces no
// output, and values 4000 and up start with MMMM. The engine emits one
// character per cycle while the output is not stalled, and takes each value
// from the queue in a step of its own before its first character; the longest
// numeral is the 15 characters of 3888. The input side keeps accepting into a
// register stage and a two-entry queue while the engine works.
module roman_numeral_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [11:0] value, [15:12] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [6:0] symbol_char, [7] zero
    output logic        o_m_axis_tlast
);

    rne_pkg::t_q_req                w_push;
    rne_pkg::t_q_req                w_head;
    logic                           w_push_ready;
    logic                           w_pop;
    logic [rne_pkg::CharWidth-1:0]  w_char;

    // accept and classify
    rne_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_value      (i_s_axis_tdata[rne_pkg::ValueWidth-1:0]),
        .o_push       (w_push),
        .i_push_ready (w_push_ready)
    );

    // decoupling queue
    rne_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // numeral engine
    rne_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_char  (w_char),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, w_char};

endmodule

/* tb/roman_numeral_encoder_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roman_numeral_encoder_chk: output checker of the roman numeral encoder
// watches both stream channels, spells each accepted value digit by digit
// and compares every output request against the oldest letter still due
// ----------------------------------------------------------------------------
module roman_numeral_encoder_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,    // [11:0] value, [15:12] zero
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,    // [6:0] symbol_char, [7] zero
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [rne_pkg::CharWidth-1:0] symbol;
        logic                          last;
    } t_letter;

    // letters of all accepted values not yet seen on the output
    t_letter letters_due[$];
    int      fails = 0;

    function automatic void put_letter(input logic [rne_pkg::CharWidth-1:0] c);
        t_letter l;
        l.symbol = c;
        l.last   = 1'b0;
        letters_due.push_back(l);
    endfunction

    // one decimal digit with its unit, five and ten letters
    function automatic void put_digit(input int d,
                                      input logic [rne_pkg::CharWidth-1:0] one,
                                      input logic [rne_pkg::CharWidth-1:0] five,
                                      input logic [rne_pkg::CharWidth-1:0] ten);
        int k;
        if (d == 9) begin
            put_letter(one);
            put_letter(ten);
        end else if (d == 4) begin
            put_letter(one);
            put_letter(five);
        end else begin
            if (d >= 5) put_letter(five);
            for (k = 0; k < d % 5; k++) put_letter(one);
        end
    endfunction

    // thousands as plain M letters, so 4000 and up start with MMMM
    function automatic void spell_numeral(input logic [rne_pkg::ValueWidth-1:0] v);
        int      n;
        int      start_len;
        int      k;
        t_letter tail;
        n         = int'(v);
        start_len = letters_due.size();
        for (k = 0; k < n / 1000; k++) put_letter(rne_pkg::CharM);
        put_digit((n / 100) % 10, rne_pkg::CharC, rne_pkg::CharD, rne_pkg::CharM);
        put_digit((n / 10) % 10, rne_pkg::CharX, rne_pkg::CharL, rne_pkg::CharC);
        put_digit(n % 10, rne_pkg::CharI, rne_pkg::CharV, rne_pkg::CharX);
        // zero leaves nothing to mark
        if (letters_due.size() > start_len) begin
            tail      = letters_due.pop_back();
            tail.last = 1'b1;
            letters_due.push_back(tail);
        end
    endfunction

    // predict on input requests, compare on output requests
    always @(posedge i_clk) begin : watch
        t_letter    want;
        logic [7:0] want_data;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                spell_numeral(i_s_tdata[rne_pkg::ValueWidth-1:0]);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (letters_due.size() == 0) begin
                    $display("%0t: unexpected output request, expected none, got %h last %b",
                             $time, i_m_tdata, i_m_tlast);
                    fails++;
                end else begin
                    want      = letters_due.pop_front();
                    want_data = {1'b0, want.symbol};
                    if (i_m_tdata !== want_data || i_m_tlast !== want.last) begin
                        $display("%0t: letter mismatch, expected %h last %b, got %h last %b",
                                 $time, want_data, want.last, i_m_tdata, i_m_tlast);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= letters_due.size();
    end

endmodule

/* tb/roman_numeral_encoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roman_numeral_encoder_tb: top of the roman numeral encoder testbench
// drives corner values and random values with random gaps on both sides,
// lets the checker compare the letter stream and reports the verdict
// ----------------------------------------------------------------------------
module roman_numeral_encoder_tb;

    localparam int StallLimit = 2000;
    localparam int DrainCycles = 40;
    localparam int RandomItems = 270;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending;
    bit          steady = 1'b0;
    int          stall_cycles = 0;

    always #1 i_clk = ~i_clk;

    roman_numeral_encoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    roman_numeral_encoder_chk i_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // gap before a request, none during steady stretches
    function automatic int draw_gap();
        return steady ? 0 : int'($urandom_range(0, 11));
    endfunction

    // random value, weighted toward zero, tiny, long and 3/4/8/9-digit numerals
    function automatic logic [11:0] pick_value();
        int sel;
        int digits [4];
        int k;
        sel = int'($urandom_range(0, 9));
        case (sel)
            0: return 12'd0;
            1: return 12'($urandom_range(1, 30));
            2: return 12'($urandom_range(3800, 4095));
            3, 4: begin
                for (k = 0; k < 4; k++) begin
                    case ($urandom_range(0, 3))
                        0: digits[k] = 3;
                        1: digits[k] = 4;
                        2: digits[k] = 8;
                        default: digits[k] = 9;
                    endcase
                end
                return 12'((digits[0] % 5) * 1000 + digits[1] * 100 + digits[2] * 10
                           + digits[3]);
            end
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // one input request; returns at the edge where it is accepted
    task automatic send(input logic [11:0] v);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, v};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // hold the input side until every letter due has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // output side: random hold-off before each request
    initial begin : sink
        int gap;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    // watchdog on cycles with no request on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= StallLimit) begin
                $display("%0t: no request for %0d cycles, %0d letters still due",
                         $time, stall_cycles, pending);
                $display("end of test: mismatches");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int i;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner values: zero, extremes, all table entries but 100 and 10, longest numeral
        send(12'd0);
        send(12'd1);
        send(12'd4095);
        send(12'd4000);
        send(12'd3888);
        send(12'd3999);
        send(12'd4);
        send(12'd9);
        send(12'd40);
        send(12'd90);
        send(12'd400);
        send(12'd900);
        send(12'd5);
        send(12'd50);
        send(12'd500);
        send(12'd1000);
        send(12'd0);
        send(12'd2048);
        send(12'd1365);
        send(12'd2730);
        send(12'd3);
        send(12'd0);
        send(12'd14);
        wait_drained();

        // random values, with a stretch of back-to-back traffic
        for (i = 0; i < RandomItems; i++) begin
            steady = (i >= 90 && i < 140);
            if (i == 180) wait_drained();
            send(pick_value());
        end
        steady = 1'b0;
        wait_drained();
        repeat (DrainCycles) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
